// ===== rtl/core/usstb_pkg.sv =====
// types and constants shared by the request telegram builder
`default_nettype none
package usstb_pkg;

  localparam logic [7:0] STX_BYTE   = 8'h02;
  localparam logic [7:0] PAD_CHAR   = 8'h20;
  localparam logic [6:0] ADR_MASK   = 7'b0011111;
  localparam logic [6:0] MIRROR_BIT = 7'b1000000;
  localparam logic [8:0] TASK_BIT8  = 9'h100;
  localparam logic [3:0] NIBBLE_MSK = 4'hF;
  localparam logic [7:0] HDR_LAST   = 8'd6;

  localparam logic [8:0] TASK_TEXT  = 9'b100001111;
  localparam logic [8:0] TASK_ZERO  = 9'b000001111;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_PARAM_WORDS   = 1'b0;
  localparam logic REG_PROCESS_WORDS = 1'b1;

  typedef enum logic [3:0] {
    SRC_STX,
    SRC_LEN,
    SRC_ADR,
    SRC_PKE_HI,
    SRC_PKE_LO,
    SRC_IDX_HI,
    SRC_IDX_LO,
    SRC_VAL,
    SRC_PZD,
    SRC_BCC
  } src_t;

  typedef struct packed {
    src_t src;
    logic rep;
    logic last;
  } ctrl_word_t;

  localparam int unsigned PROG_LEN = 10;
  localparam int unsigned STEP_W   = $clog2(PROG_LEN);

  localparam ctrl_word_t PROG [PROG_LEN] = '{
    '{src: SRC_STX,    rep: 1'b0, last: 1'b0},
    '{src: SRC_LEN,    rep: 1'b0, last: 1'b0},
    '{src: SRC_ADR,    rep: 1'b0, last: 1'b0},
    '{src: SRC_PKE_HI, rep: 1'b0, last: 1'b0},
    '{src: SRC_PKE_LO, rep: 1'b0, last: 1'b0},
    '{src: SRC_IDX_HI, rep: 1'b0, last: 1'b0},
    '{src: SRC_IDX_LO, rep: 1'b0, last: 1'b0},
    '{src: SRC_VAL,    rep: 1'b1, last: 1'b0},
    '{src: SRC_PZD,    rep: 1'b1, last: 1'b0},
    '{src: SRC_BCC,    rep: 1'b0, last: 1'b1}
  };

endpackage
`default_nettype wire

// ===== rtl/core/uss_request_telegram_builder_core.sv =====
// top level of the request telegram builder: sequencer, datapath and register port
`default_nettype none
// One request beat in gives one telegram out, one byte beat per cycle while the
// output is taken: STX, length, address, PKE, index, the value field (0, 2, 4
// or 16 bytes by task), two bytes per process word and the XOR check byte,
// which carries out_last_byte. A telegram holds up to 56 bytes with the default
// MAX_PROCESS_WORDS. Each of the value and process steps of the control program
// that has nothing to send still takes a sequencer step that emits no byte.
// in_ready rises when the check byte enters the output register, so no new
// request beat is accepted while a telegram is being built. The sequencer
// stalls whenever out_ready is low while a byte waits.
module uss_request_telegram_builder_core #(
  parameter int unsigned MAX_PROCESS_WORDS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [4:0]                         in_station_address,
  input  wire logic                               in_mirror_flag,
  input  wire logic [8:0]                         in_task_id,
  input  wire logic [11:0]                        in_param_number,
  input  wire logic [15:0]                        in_param_index,
  input  wire logic [31:0]                        in_param_value,
  input  wire logic [15:0]                        in_process_word,
  input  wire logic                               in_process_word_present,
  input  wire logic [63:0]                        in_text_low,
  input  wire logic [63:0]                        in_text_high,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              out_tx_byte,
  output logic                                    out_last_byte,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [usstb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import usstb_pkg::*;

  localparam int unsigned PCW = $clog2(2 * MAX_PROCESS_WORDS + 1);

  logic [2:0]        param_words_r;
  logic [4:0]        process_words_r;
  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [7:0]        len_r;
  logic [6:0]        adr_r;
  logic [15:0]       pke_r;
  logic [15:0]       idx_r;
  logic [15:0]       pzd_r;
  logic [127:0]      vbuf_r;
  logic              text_r;
  logic              ended_r;
  logic [4:0]        vcnt_r;
  logic [PCW-1:0]    pcnt_r;
  logic [7:0]        bcc_r;
  logic              out_valid_r;
  logic [7:0]        out_tx_byte_r;
  logic              out_last_byte_r;

  logic              cfg_wr;
  logic              accept;
  logic              four;
  logic [4:0]        npzd;
  logic [4:0]        vlen;
  logic [127:0]      vbuf_load;
  logic              text_load;
  logic [15:0]       v16;
  logic [127:0]      text_all;
  logic [127:0]      text_bytes;
  logic [PCW-1:0]    pcnt_load;
  ctrl_word_t        cw;
  logic              room;
  logic              cnt_zero;
  logic              cnt_one;
  logic              emit;
  logic              step_adv;
  logic [7:0]        ch;
  logic [7:0]        byte_sel;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_PROCESS_WORDS) ? {27'd0, process_words_r}
                                                    : {29'd0, param_words_r};
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_words_r   <= 3'd4;
      process_words_r <= 5'd2;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PARAM_WORDS) begin
        param_words_r <= pwdata[2:0];
      end else begin
        process_words_r <= pwdata[4:0];
      end
    end
  end

  // value field setup
  assign four = param_words_r >= 3'd4;
  assign npzd = (process_words_r > 5'(MAX_PROCESS_WORDS)) ? 5'(MAX_PROCESS_WORDS)
                                                          : process_words_r;
  assign pcnt_load = PCW'({npzd, 1'b0});
  assign text_all  = {in_text_high, in_text_low};

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      text_bytes[127-8*k -: 8] = text_all[8*k +: 8];
    end
  end

  always_comb begin
    vbuf_load = '0;
    vlen      = 5'd0;
    text_load = 1'b0;
    v16       = in_param_value[15:0];
    case (in_task_id) inside
      9'h000, 9'h001, 9'h002, 9'h006, 9'h007, 9'h009, 9'h00C, 9'h00E: begin
        if (in_task_id == 9'h001 || in_task_id == 9'h006 || in_task_id == 9'h009) begin
          v16 = 16'd0;
        end
        if (four) begin
          vbuf_load = {16'd0, v16, 96'd0};
          vlen      = 5'd4;
        end else begin
          vbuf_load = {v16, 112'd0};
          vlen      = 5'd2;
        end
      end
      9'h003, 9'h008, 9'h00D: begin
        vbuf_load = {in_param_value, 96'd0};
        vlen      = 5'd4;
      end
      TASK_TEXT: begin
        vbuf_load = text_bytes;
        vlen      = 5'd16;
        text_load = 1'b1;
      end
      TASK_ZERO: begin
        vlen = four ? 5'd4 : 5'd2;
      end
      default: begin
        vlen = 5'd0;
      end
    endcase
  end

  // sequencer
  assign cw       = PROG[step_r];
  assign room     = !out_valid_r || out_ready;
  assign cnt_zero = (cw.src == SRC_VAL) ? (vcnt_r == 5'd0) : (pcnt_r == '0);
  assign cnt_one  = (cw.src == SRC_VAL) ? (vcnt_r == 5'd1) : (pcnt_r == PCW'(1));
  assign emit     = busy_r && room && !(cw.rep && cnt_zero);
  assign step_adv = busy_r && room && (!cw.rep || cnt_zero || cnt_one);
  assign ch       = vbuf_r[127:120];

  always_comb begin
    case (cw.src)
      SRC_STX:    byte_sel = STX_BYTE;
      SRC_LEN:    byte_sel = len_r;
      SRC_ADR:    byte_sel = {1'b0, adr_r};
      SRC_PKE_HI: byte_sel = pke_r[15:8];
      SRC_PKE_LO: byte_sel = pke_r[7:0];
      SRC_IDX_HI: byte_sel = idx_r[15:8];
      SRC_IDX_LO: byte_sel = idx_r[7:0];
      SRC_VAL:    byte_sel = (text_r && (ch == 8'd0 || ended_r)) ? PAD_CHAR : ch;
      SRC_PZD:    byte_sel = pcnt_r[0] ? pzd_r[7:0] : pzd_r[15:8];
      SRC_BCC:    byte_sel = bcc_r;
      default:    byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (step_adv) begin
      if (cw.last) begin
        busy_r <= 1'b0;
        step_r <= '0;
      end else begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      adr_r   <= ({2'd0, in_station_address} & ADR_MASK) |
                 (in_mirror_flag ? MIRROR_BIT : 7'd0);
      pke_r   <= {in_task_id[3:0] & NIBBLE_MSK, in_param_number};
      idx_r   <= in_param_index | {7'd0, in_task_id & TASK_BIT8};
      pzd_r   <= in_process_word_present ? in_process_word : 16'd0;
      vbuf_r  <= vbuf_load;
      text_r  <= text_load;
      ended_r <= 1'b0;
      vcnt_r  <= vlen;
      pcnt_r  <= pcnt_load;
      len_r   <= HDR_LAST + 8'(vlen) + 8'(pcnt_load);
      bcc_r   <= 8'd0;
    end else if (emit) begin
      bcc_r <= bcc_r ^ byte_sel;
      if (cw.src == SRC_VAL) begin
        vbuf_r  <= {vbuf_r[119:0], 8'd0};
        ended_r <= ended_r || (text_r && ch == 8'd0);
        vcnt_r  <= vcnt_r - 5'd1;
      end
      if (cw.src == SRC_PZD) begin
        pcnt_r <= pcnt_r - PCW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tx_byte_r   <= byte_sel;
      out_last_byte_r <= cw.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_last_byte = out_last_byte_r;

endmodule
`default_nettype wire
